>>> design/dq_pkg.sv
// Shared constants, item types and slot helpers for the double-ended queue.
package dq_pkg;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW         = $clog2(DEPTH + 1);

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned POS_W      = 4;
  localparam int unsigned COUNT_W    = 5;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_BACK  = 3'd5,
    OP_GET        = 3'd6,
    OP_CLEAR      = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    op_e                op;
    logic [WORD_W-1:0]  value;
    logic [POS_W-1:0]   position;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0]  read_word;
    status_e            status;
    logic [COUNT_W-1:0] count;
    logic               is_empty;
  } out_item_t;

  // Memory access and result status for one accepted item.
  typedef struct packed {
    logic          wr_en;
    logic          rd_en;
    logic [AW-1:0] addr;
    status_e       status;
    logic [CW-1:0] count;
  } acc_t;

  function automatic logic [AW-1:0] slot_next(input logic [AW-1:0] s);
    return (s == AW'(DEPTH - 1)) ? '0 : s + AW'(1);
  endfunction

  function automatic logic [AW-1:0] slot_prev(input logic [AW-1:0] s);
    return (s == '0) ? AW'(DEPTH - 1) : s - AW'(1);
  endfunction

endpackage

>>> design/double_ended_queue.sv
// Top level of the double-ended queue: handshakes, result pipeline, checks.
//
// Bounded deque of DEPTH data words held as a ring in one synchronous RAM.
// Input channel (in_valid_i / in_ready_o / in_item_i): one item is one
// operation - push front/back, pop front/back, peek front/back, get by
// position from the front, or clear.
// Output channel (out_valid_o / out_ready_i / out_item_o): exactly one
// result per item, in order: data word, status, count after, empty flag.
// The RAM access and the stage 1 registers load at the accept edge, then
// the output register that drives out_item_o loads once stage 1 moves on.
// Throughput: one item per cycle while the receiver keeps up. Pointers update
// at the accept edge, so the next item sees them at once; the RAM write also
// lands at that edge, so a read in the following cycle already sees the new word.
// Reset clears head, tail, count and all valid flags; RAM contents are
// not cleared (only slots holding items are ever read), no clearing pass.
// Receiver stall: the output register holds its result, the middle stage
// fills, then in_ready_o drops; nothing is lost or repeated.
module double_ended_queue
  import dq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  // handshake
  logic accept;
  logic s1_move;

  // stage 1: RAM access in flight
  logic          s1_valid_q;
  logic          s1_rd_q;
  status_e       s1_status_q;
  logic [CW-1:0] s1_count_q;

  // output register
  logic          out_valid_q;
  out_item_t     out_item_q;

  acc_t                  acc;
  logic [DATA_WIDTH-1:0] rdata;

  // Stage 1 moves on whenever the output register is free or being drained.
  assign s1_move    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_move;
  assign accept     = in_valid_i && in_ready_o;

  dq_ptr u_ptr (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .op_i       (in_item_i.op),
    .position_i (in_item_i.position),
    .acc_o      (acc)
  );

  dq_ram #(
    .DEPTH (DEPTH),
    .WIDTH (DATA_WIDTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (acc.wr_en),
    .re_i    (acc.rd_en),
    .addr_i  (acc.addr),
    .wdata_i (DATA_WIDTH'(in_item_i.value)),
    .rdata_o (rdata)
  );

  // Stage 1 control; the read word itself waits in the RAM output register,
  // which only reloads on the next accept, after this stage has moved.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_rd_q     <= acc.rd_en;
      s1_status_q <= acc.status;
      s1_count_q  <= acc.count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      // push, clear and refused items give a zero word
      out_item_q.read_word <= s1_rd_q ? WORD_W'(rdata) : '0;
      out_item_q.status    <= s1_status_q;
      out_item_q.count     <= COUNT_W'(s1_count_q);
      out_item_q.is_empty  <= (s1_count_q == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------

  // Count never exceeds the ring size.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.count <= COUNT_W'(DEPTH)))
    else $error("result count exceeds depth");

  // Empty flag agrees with the count.
  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.is_empty == (out_item_o.count == '0)))
    else $error("empty flag disagrees with count");

  // A refused item returns a zero word.
  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_item_o.status != ST_OK)) |-> (out_item_o.read_word == '0))
    else $error("refused item returned data");

  // The RAM is never written and read in the same cycle.
  a_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(acc.wr_en && acc.rd_en))
    else $error("RAM written and read in one cycle");

endmodule

>>> design/dq_ram.sv
// Single-port synchronous RAM with a registered read.
module dq_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/dq_ptr.sv
// Head, tail and count registers; decodes each item into a memory access.
module dq_ptr
  import dq_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  op_e              op_i,
  input  logic [POS_W-1:0] position_i,
  output acc_t             acc_o
);

  logic [AW-1:0] head_q, head_d;
  logic [AW-1:0] tail_q, tail_d;
  logic [CW-1:0] count_q, count_d;

  logic          full, empty;
  logic [AW:0]   get_sum;
  logic [AW:0]   get_wrap;
  acc_t          acc;

  assign full     = (count_q == CW'(DEPTH));
  assign empty    = (count_q == '0);
  assign get_sum  = {1'b0, head_q} + {1'b0, AW'(position_i)};
  assign get_wrap = (get_sum >= (AW+1)'(DEPTH)) ? get_sum - (AW+1)'(DEPTH) : get_sum;

  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    acc.wr_en  = 1'b0;
    acc.rd_en  = 1'b0;
    acc.addr   = head_q;
    acc.status = ST_OK;
    case (op_i)
      OP_PUSH_FRONT: begin
        acc.addr = slot_prev(head_q);
        if (full) begin
          acc.status = ST_FULL;
        end else begin
          acc.wr_en = 1'b1;
          head_d    = slot_prev(head_q);
          count_d   = count_q + CW'(1);
        end
      end
      OP_PUSH_BACK: begin
        acc.addr = tail_q;
        if (full) begin
          acc.status = ST_FULL;
        end else begin
          acc.wr_en = 1'b1;
          tail_d    = slot_next(tail_q);
          count_d   = count_q + CW'(1);
        end
      end
      OP_POP_FRONT: begin
        acc.addr = head_q;
        if (empty) begin
          acc.status = ST_EMPTY;
        end else begin
          acc.rd_en = 1'b1;
          head_d    = slot_next(head_q);
          count_d   = count_q - CW'(1);
        end
      end
      OP_POP_BACK: begin
        acc.addr = slot_prev(tail_q);
        if (empty) begin
          acc.status = ST_EMPTY;
        end else begin
          acc.rd_en = 1'b1;
          tail_d    = slot_prev(tail_q);
          count_d   = count_q - CW'(1);
        end
      end
      OP_PEEK_FRONT: begin
        acc.addr = head_q;
        if (empty) acc.status = ST_EMPTY;
        else       acc.rd_en  = 1'b1;
      end
      OP_PEEK_BACK: begin
        acc.addr = slot_prev(tail_q);
        if (empty) acc.status = ST_EMPTY;
        else       acc.rd_en  = 1'b1;
      end
      OP_GET: begin
        acc.addr = get_wrap[AW-1:0];
        // compare at full width: position may reach or exceed the item count
        if ({{(COUNT_W){1'b0}}, position_i} >= (COUNT_W+POS_W)'(count_q)) begin
          acc.status = ST_EMPTY;
        end else begin
          acc.rd_en = 1'b1;
        end
      end
      OP_CLEAR: begin
        head_d  = '0;
        tail_d  = '0;
        count_d = '0;
      end
      default: ;
    endcase
    acc.count = count_d;
    acc.wr_en = acc.wr_en & accept_i;
    acc.rd_en = acc.rd_en & accept_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else if (accept_i) begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  assign acc_o = acc;

endmodule
